[rtl/core/scsa_pkg.sv]
// Package for the size-class slab allocator core.
// Holds the shared constants, the controller/datapath command and status types.
// No dependencies.
package scsa_pkg;

  localparam int FRAME_SIZE_LOG = 21;
  localparam int MIN_OBJ_LOG    = 5;
  localparam int WORD_LOG       = 10;
  localparam int ADDR_W         = 48;
  localparam int PFN_W          = 27;
  localparam int SIZE_W         = 21;
  localparam int USED_W         = 17;
  localparam int TOTAL_W        = 22;
  localparam int FINFO_W        = 1 + 4 + USED_W;
  localparam logic [SIZE_W-1:0] MAX_SIZE = 21'd1048576;

  typedef enum logic [2:0] {
    RES_OK           = 3'd0,
    RES_TOO_LARGE    = 3'd1,
    RES_OUT_OF_MEM   = 3'd2,
    RES_NOT_FOUND    = 3'd3,
    RES_ALREADY_FREE = 3'd4
  } res_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_A_FRD,
    OP_A_FCHK,
    OP_A_WRD,
    OP_A_WCHK,
    OP_A_COMMIT,
    OP_F_FRD,
    OP_F_FCHK,
    OP_F_WRD,
    OP_F_WCHK,
    OP_F_COMMIT
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_A_FRD,
    S_A_FCHK,
    S_A_WRD,
    S_A_WCHK,
    S_A_COMMIT,
    S_F_FRD,
    S_F_FCHK,
    S_F_WRD,
    S_F_WCHK,
    S_F_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    logic set_res;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic size_ok;
    logic rel_ok;
    logic frm_hit;
    logic last_frame;
    logic any_unused;
    logic word_full;
    logic frm_valid;
    logic bit_set;
  } sts_t;

  function automatic logic [USED_W-1:0] cap_of(input logic [3:0] k);
    return USED_W'(1) << (5'd16 - {1'b0, k});
  endfunction

endpackage

[rtl/core/scsa_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module scsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/scsa_ctrl.sv]
// Controller state machine of the slab allocator core.
// Depends on scsa_pkg; drives commands to scsa_dpath and reads its status.
module scsa_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  scsa_pkg::sts_t sts,
  output scsa_pkg::cmd_t cmd,
  output logic           busy,
  output logic           done
);

  scsa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scsa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd.op      = scsa_pkg::OP_IDLE;
    cmd.set_res = 1'b0;
    cmd.res     = scsa_pkg::RES_OK;
    unique case (state)
      scsa_pkg::S_CLEAR: begin
        cmd.op = scsa_pkg::OP_CLEAR;
        if (sts.clear_last) state_next = scsa_pkg::S_IDLE;
      end
      scsa_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = scsa_pkg::OP_LOAD;
          state_next = scsa_pkg::S_DISPATCH;
        end
      end
      scsa_pkg::S_DISPATCH: begin
        if (sts.is_free) begin
          state_next = scsa_pkg::S_F_FRD;
        end else if (!sts.size_ok) begin
          cmd.set_res = 1'b1;
          cmd.res     = scsa_pkg::RES_TOO_LARGE;
          state_next  = scsa_pkg::S_DONE;
        end else begin
          state_next = scsa_pkg::S_A_FRD;
        end
      end
      scsa_pkg::S_A_FRD: begin
        cmd.op     = scsa_pkg::OP_A_FRD;
        state_next = scsa_pkg::S_A_FCHK;
      end
      scsa_pkg::S_A_FCHK: begin
        cmd.op = scsa_pkg::OP_A_FCHK;
        if (sts.frm_hit) begin
          state_next = scsa_pkg::S_A_WRD;
        end else if (sts.last_frame) begin
          if (sts.any_unused) begin
            state_next = scsa_pkg::S_A_COMMIT;
          end else begin
            cmd.set_res = 1'b1;
            cmd.res     = scsa_pkg::RES_OUT_OF_MEM;
            state_next  = scsa_pkg::S_DONE;
          end
        end else begin
          state_next = scsa_pkg::S_A_FRD;
        end
      end
      scsa_pkg::S_A_WRD: begin
        cmd.op     = scsa_pkg::OP_A_WRD;
        state_next = scsa_pkg::S_A_WCHK;
      end
      scsa_pkg::S_A_WCHK: begin
        cmd.op     = scsa_pkg::OP_A_WCHK;
        state_next = sts.word_full ? scsa_pkg::S_A_WRD : scsa_pkg::S_A_COMMIT;
      end
      scsa_pkg::S_A_COMMIT: begin
        cmd.op     = scsa_pkg::OP_A_COMMIT;
        state_next = scsa_pkg::S_DONE;
      end
      scsa_pkg::S_F_FRD: begin
        cmd.op = scsa_pkg::OP_F_FRD;
        if (!sts.rel_ok) begin
          cmd.set_res = 1'b1;
          cmd.res     = scsa_pkg::RES_NOT_FOUND;
          state_next  = scsa_pkg::S_DONE;
        end else begin
          state_next = scsa_pkg::S_F_FCHK;
        end
      end
      scsa_pkg::S_F_FCHK: begin
        cmd.op = scsa_pkg::OP_F_FCHK;
        if (!sts.frm_valid) begin
          cmd.set_res = 1'b1;
          cmd.res     = scsa_pkg::RES_NOT_FOUND;
          state_next  = scsa_pkg::S_DONE;
        end else begin
          state_next = scsa_pkg::S_F_WRD;
        end
      end
      scsa_pkg::S_F_WRD: begin
        cmd.op     = scsa_pkg::OP_F_WRD;
        state_next = scsa_pkg::S_F_WCHK;
      end
      scsa_pkg::S_F_WCHK: begin
        cmd.op = scsa_pkg::OP_F_WCHK;
        if (!sts.bit_set) begin
          cmd.set_res = 1'b1;
          cmd.res     = scsa_pkg::RES_ALREADY_FREE;
          state_next  = scsa_pkg::S_DONE;
        end else begin
          state_next = scsa_pkg::S_F_COMMIT;
        end
      end
      scsa_pkg::S_F_COMMIT: begin
        cmd.op     = scsa_pkg::OP_F_COMMIT;
        state_next = scsa_pkg::S_DONE;
      end
      scsa_pkg::S_DONE: begin
        state_next = scsa_pkg::S_IDLE;
      end
      default: state_next = scsa_pkg::S_IDLE;
    endcase
  end

  assign busy = (state != scsa_pkg::S_IDLE);
  assign done = (state == scsa_pkg::S_DONE);

endmodule

[rtl/core/scsa_dpath.sv]
// Datapath of the slab allocator core: request registers, frame table and
// object bitmap memories, class free totals and result registers.
// Depends on scsa_pkg and scsa_ram.
module scsa_dpath #(
  parameter int FRAME_COUNT = 32,
  parameter int CLASS_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  scsa_pkg::cmd_t                      cmd,
  output scsa_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [scsa_pkg::PFN_W-1:0]          cfg_data,
  input  logic                                action,
  input  logic [scsa_pkg::SIZE_W-1:0]         request_size,
  input  logic [scsa_pkg::ADDR_W-1:0]         free_address,
  output logic [2:0]                          status,
  output logic [scsa_pkg::ADDR_W-1:0]         object_address,
  output logic [3:0]                          size_class,
  output logic                                frame_released
);

  localparam int FW   = $clog2(FRAME_COUNT);
  localparam int BMA  = FW + scsa_pkg::WORD_LOG;
  localparam int BM_D = FRAME_COUNT << scsa_pkg::WORD_LOG;
  localparam int UW   = scsa_pkg::USED_W;
  localparam int TW   = scsa_pkg::TOTAL_W;

  logic [scsa_pkg::PFN_W-1:0]  pool_base;
  logic                        req_free;
  logic [scsa_pkg::SIZE_W-1:0] req_size;
  logic [scsa_pkg::ADDR_W-1:0] req_addr;
  logic [BMA-1:0]              clr_idx;
  logic [FW-1:0]               frm;
  logic [FW-1:0]               unused_idx;
  logic                        unused_seen;
  logic                        new_frame;
  logic [UW-1:0]               frm_used;
  logic [3:0]                  k_reg;
  logic [9:0]                  word;
  logic [63:0]                 word_data;
  logic [5:0]                  bitpos;
  logic [TW-1:0]               free_tot [CLASS_COUNT];

  logic [2:0]                  res_status;
  logic [scsa_pkg::ADDR_W-1:0] res_addr;
  logic [3:0]                  res_cls;
  logic                        res_rel;

  logic                          f_we, b_we;
  logic [FW-1:0]                 f_addr;
  logic [BMA-1:0]                b_addr;
  logic [scsa_pkg::FINFO_W-1:0]  f_wdata, f_rdata;
  logic [63:0]                   b_wdata, b_rdata;

  logic [3:0]                  akls;
  logic                        afound;
  logic [3:0]                  cur_k;
  logic [UW-1:0]               cap;
  logic                        owned;
  logic [3:0]                  fcls;
  logic [UW-1:0]               fused;
  logic [5:0]                  lz;
  logic [scsa_pkg::PFN_W-1:0]  rel;
  logic [15:0]                 fobj;
  logic [15:0]                 aobj;
  logic [20:0]                 aoff;
  logic [UW-1:0]               used_dec;
  logic [TW-1:0]               ft;
  logic [TW-1:0]               thresh;
  logic                        release_now;
  logic [FW-1:0]               claim_idx;

  scsa_ram #(.WIDTH(scsa_pkg::FINFO_W), .DEPTH(FRAME_COUNT)) u_frame_ram (
    .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
  );

  scsa_ram #(.WIDTH(64), .DEPTH(BM_D)) u_bitmap_ram (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wdata), .rdata(b_rdata)
  );

  always_comb begin
    afound = 1'b0;
    akls   = 4'd0;
    for (int c = 0; c < 16; c++) begin
      if (!afound && c < CLASS_COUNT &&
          {1'b0, req_size} <= (22'd32 << c)) begin
        afound = 1'b1;
        akls   = 4'(c);
      end
    end
  end

  always_comb begin
    lz = 6'd0;
    for (int i = 63; i >= 0; i--) begin
      if (!b_rdata[i]) lz = 6'(i);
    end
  end

  assign cur_k     = req_free ? k_reg : akls;
  assign cap       = scsa_pkg::cap_of(cur_k);
  assign owned     = f_rdata[scsa_pkg::FINFO_W-1];
  assign fcls      = f_rdata[UW+3:UW];
  assign fused     = f_rdata[UW-1:0];
  assign rel       = req_addr[scsa_pkg::ADDR_W-1:scsa_pkg::FRAME_SIZE_LOG] - pool_base;
  assign fobj      = req_addr[20:5] >> k_reg;
  assign aobj      = {word, bitpos};
  assign aoff      = {aobj, 5'd0} << akls;
  assign used_dec  = frm_used - UW'(1);
  assign ft        = free_tot[k_reg] + TW'(1);
  assign thresh    = TW'(cap) + TW'(cap[UW-1:1]);
  assign release_now = (used_dec == '0) && (frm >= FW'(CLASS_COUNT)) && (ft >= thresh);
  assign claim_idx = unused_seen ? unused_idx : frm;

  always_comb begin
    sts.clear_last = (clr_idx == BMA'(BM_D - 1));
    sts.is_free    = req_free;
    sts.size_ok    = afound && (req_size <= scsa_pkg::MAX_SIZE);
    sts.rel_ok     = rel < scsa_pkg::PFN_W'(FRAME_COUNT);
    sts.frm_hit    = owned && (fcls == akls) && (fused < cap);
    sts.last_frame = (frm == FW'(FRAME_COUNT - 1));
    sts.any_unused = unused_seen || !owned;
    sts.word_full  = &b_rdata;
    sts.frm_valid  = owned && ({1'b0, fcls} < 5'(CLASS_COUNT));
    sts.bit_set    = b_rdata[fobj[5:0]];
  end

  always_comb begin
    f_we    = 1'b0;
    f_addr  = frm;
    f_wdata = '0;
    b_we    = 1'b0;
    b_addr  = {frm, word};
    b_wdata = '0;
    unique case (cmd.op)
      scsa_pkg::OP_CLEAR: begin
        b_we   = 1'b1;
        b_addr = clr_idx;
        f_we   = clr_idx < BMA'(FRAME_COUNT);
        f_addr = clr_idx[FW-1:0];
        if (clr_idx < BMA'(CLASS_COUNT)) begin
          f_wdata = {1'b1, clr_idx[3:0], UW'(0)};
        end
      end
      scsa_pkg::OP_A_COMMIT: begin
        b_we    = 1'b1;
        b_wdata = word_data | (64'd1 << bitpos);
        f_we    = 1'b1;
        f_wdata = {1'b1, akls, frm_used + UW'(1)};
      end
      scsa_pkg::OP_F_FRD: begin
        f_addr = rel[FW-1:0];
      end
      scsa_pkg::OP_F_WRD: begin
        b_addr = {frm, fobj[15:6]};
      end
      scsa_pkg::OP_F_COMMIT: begin
        b_we    = 1'b1;
        b_addr  = {frm, fobj[15:6]};
        b_wdata = word_data & ~(64'd1 << fobj[5:0]);
        f_we    = 1'b1;
        f_wdata = release_now ? '0 : {1'b1, k_reg, used_dec};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      clr_idx   <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        free_tot[i] <= TW'(scsa_pkg::cap_of(4'(i)));
      end
    end else begin
      if (cfg_we) pool_base <= cfg_data;
      unique case (cmd.op)
        scsa_pkg::OP_CLEAR: clr_idx <= clr_idx + BMA'(1);
        scsa_pkg::OP_A_COMMIT: begin
          free_tot[akls] <= new_frame ? free_tot[akls] + TW'(cap) - TW'(1)
                                      : free_tot[akls] - TW'(1);
        end
        scsa_pkg::OP_F_COMMIT: begin
          free_tot[k_reg] <= release_now ? ft - TW'(cap) : ft;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      scsa_pkg::OP_LOAD: begin
        req_free    <= action;
        req_size    <= request_size;
        req_addr    <= free_address;
        frm         <= '0;
        unused_seen <= 1'b0;
        new_frame   <= 1'b0;
      end
      scsa_pkg::OP_A_FCHK: begin
        if (sts.frm_hit) begin
          frm_used <= fused;
          word     <= '0;
        end else begin
          if (!unused_seen && !owned) begin
            unused_seen <= 1'b1;
            unused_idx  <= frm;
          end
          if (sts.last_frame) begin
            frm       <= claim_idx;
            new_frame <= 1'b1;
            frm_used  <= '0;
            word      <= '0;
            word_data <= '0;
            bitpos    <= '0;
          end else begin
            frm <= frm + FW'(1);
          end
        end
      end
      scsa_pkg::OP_A_WCHK: begin
        if (sts.word_full) begin
          word <= word + 10'd1;
        end else begin
          word_data <= b_rdata;
          bitpos    <= lz;
        end
      end
      scsa_pkg::OP_A_COMMIT: begin
        res_status <= scsa_pkg::RES_OK;
        res_addr   <= {pool_base + scsa_pkg::PFN_W'(frm), aoff};
        res_cls    <= akls;
        res_rel    <= 1'b0;
      end
      scsa_pkg::OP_F_FRD: begin
        frm <= rel[FW-1:0];
      end
      scsa_pkg::OP_F_FCHK: begin
        k_reg    <= fcls;
        frm_used <= fused;
      end
      scsa_pkg::OP_F_WCHK: begin
        word_data <= b_rdata;
      end
      scsa_pkg::OP_F_COMMIT: begin
        res_status <= scsa_pkg::RES_OK;
        res_addr   <= '0;
        res_cls    <= k_reg;
        res_rel    <= release_now;
      end
      default: begin
      end
    endcase
    if (cmd.set_res) begin
      res_status <= cmd.res;
      res_addr   <= '0;
      res_rel    <= 1'b0;
      res_cls    <= (cmd.res == scsa_pkg::RES_OUT_OF_MEM ||
                     cmd.res == scsa_pkg::RES_ALREADY_FREE) ? cur_k : 4'd0;
    end
  end

  assign status         = res_status;
  assign object_address = res_addr;
  assign size_class     = res_cls;
  assign frame_released = res_rel;

endmodule

[rtl/core/size_class_slab_allocator_core.sv]
// Top level of the size-class slab allocator core.
// Depends on scsa_pkg, scsa_ctrl and scsa_dpath.
//
// A request is transferred when start is high and busy is low: action selects
// allocate or free, with request_size or free_address as its operand. The
// result appears on status, object_address, size_class and frame_released and
// is marked by done, a one-cycle strobe; the receiver cannot hold it off.
// An allocate scans the frame table frame by frame and then the bitmap words
// of the chosen frame word by word. A free reads the frame entry and then the
// object's bitmap word, then writes both back. Both are bounded by the single
// port of the frame table and bitmap memories. One request is in flight at a
// time.
// After reset the bitmap memory is cleared one word per cycle, busy held high.
// The pool base frame register is written through cfg_valid and cfg_ready,
// which is always ready; it should be written only while the core is idle.
module size_class_slab_allocator_core #(
  parameter int FRAME_COUNT = 32,
  parameter int CLASS_COUNT = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  output logic                        done,
  input  logic                        action,
  input  logic [scsa_pkg::SIZE_W-1:0] request_size,
  input  logic [scsa_pkg::ADDR_W-1:0] free_address,
  output logic [2:0]                  status,
  output logic [scsa_pkg::ADDR_W-1:0] object_address,
  output logic [3:0]                  size_class,
  output logic                        frame_released,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [scsa_pkg::PFN_W-1:0]  cfg_data
);

  scsa_pkg::cmd_t cmd;
  scsa_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  scsa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd),
    .busy(busy), .done(done)
  );

  scsa_dpath #(.FRAME_COUNT(FRAME_COUNT), .CLASS_COUNT(CLASS_COUNT)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_valid & cfg_ready), .cfg_data(cfg_data),
    .action(action), .request_size(request_size), .free_address(free_address),
    .status(status), .object_address(object_address),
    .size_class(size_class), .frame_released(frame_released)
  );

endmodule

[bench/tb_size_class_slab_allocator_core.sv]
// Testbench for the size-class slab allocator core: directed and random
// allocate/free traffic checked against a predictor of the allocator state.
// Depends on scsa_pkg and size_class_slab_allocator_core.
module tb_size_class_slab_allocator_core;

  localparam int NUM_FRAMES  = 32;
  localparam int NUM_CLASSES = 16;
  localparam int WORDS_PER_FRAME = 1024;
  localparam int WATCHDOG_LIMIT = 120000;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;
  localparam logic [4:0] OWNED = 5'h10;

  typedef struct packed {
    logic [2:0]                  status;
    logic [scsa_pkg::ADDR_W-1:0] addr;
    logic [3:0]                  cls;
    logic                        released;
  } alloc_result_t;

  typedef struct packed {
    logic [scsa_pkg::ADDR_W-1:0] addr;
    logic [3:0]                  cls;
  } live_object_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic action = 1'b0;
  logic [scsa_pkg::SIZE_W-1:0] request_size = '0;
  logic [scsa_pkg::ADDR_W-1:0] free_address = '0;
  logic cfg_valid = 1'b0;
  logic [scsa_pkg::PFN_W-1:0] cfg_data = '0;
  logic busy, done, frame_released, cfg_ready;
  logic [2:0] status;
  logic [scsa_pkg::ADDR_W-1:0] object_address;
  logic [3:0] size_class;

  size_class_slab_allocator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .action(action), .request_size(request_size), .free_address(free_address),
    .status(status), .object_address(object_address), .size_class(size_class),
    .frame_released(frame_released), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predicted allocator state.
  logic [scsa_pkg::PFN_W-1:0] base_frame;
  logic [4:0]       owner_of [NUM_FRAMES];
  logic [63:0]      slab_map [NUM_FRAMES*WORDS_PER_FRAME];
  int unsigned      frame_in_use [NUM_FRAMES];
  int unsigned      class_free [NUM_CLASSES];
  int unsigned      class_used [NUM_CLASSES];

  alloc_result_t pending_results[$];
  live_object_t  live_objects[$];
  logic [scsa_pkg::ADDR_W-1:0] freed_recently[$];
  int errors = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;

  function automatic int unsigned class_capacity(int unsigned k);
    return 32'd1 << (16 - k);
  endfunction

  task automatic reset_model();
    base_frame = '0;
    foreach (slab_map[i]) slab_map[i] = '0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      owner_of[f] = (f < NUM_CLASSES) ? (OWNED | 5'(f)) : 5'd0;
      frame_in_use[f] = 0;
    end
    for (int k = 0; k < NUM_CLASSES; k++) begin
      class_free[k] = class_capacity(k);
      class_used[k] = 0;
    end
  endtask

  function automatic int unsigned first_clear_slot(int f, int unsigned k);
    int unsigned capacity;
    logic [63:0] w;
    capacity = class_capacity(k);
    for (int unsigned j = 0; j < capacity; j++) begin
      w = slab_map[f*WORDS_PER_FRAME + (j >> 6)];
      if (&w) begin
        j += 63;
        continue;
      end
      if (!w[j[5:0]]) return j;
    end
    return capacity;
  endfunction

  task automatic predict_request(input logic act, input logic [scsa_pkg::SIZE_W-1:0] sz,
                                 input logic [scsa_pkg::ADDR_W-1:0] fa,
                                 output alloc_result_t r);
    int unsigned k, capacity, slot, f;
    int hit;
    logic [scsa_pkg::PFN_W-1:0] pfn, rel;
    logic [63:0] bit_mask;
    int word_idx;
    r = '0;
    r.status = scsa_pkg::RES_OK;
    if (act == ACT_ALLOC) begin
      k = 0;
      while (k < NUM_CLASSES && (64'd1 << (5 + k)) < sz) k++;
      if (k >= NUM_CLASSES || sz > scsa_pkg::MAX_SIZE) begin
        r.status = scsa_pkg::RES_TOO_LARGE;
        return;
      end
      capacity = class_capacity(k);
      r.cls = 4'(k);
      hit = -1;
      slot = 0;
      for (f = 0; f < NUM_FRAMES; f++) begin
        if (owner_of[f] == (OWNED | 5'(k)) && frame_in_use[f] < capacity) begin
          slot = first_clear_slot(f, k);
          if (slot < capacity) begin
            hit = f;
            break;
          end
        end
      end
      if (hit < 0) begin
        for (f = 0; f < NUM_FRAMES; f++) begin
          if (!owner_of[f][4]) begin
            hit = f;
            break;
          end
        end
        if (hit >= 0) begin
          owner_of[hit] = OWNED | 5'(k);
          class_free[k] += capacity;
          slot = 0;
        end
      end
      if (hit < 0) begin
        r.status = scsa_pkg::RES_OUT_OF_MEM;
        return;
      end
      pfn = base_frame + scsa_pkg::PFN_W'(hit);
      slab_map[hit*WORDS_PER_FRAME + (slot >> 6)][slot[5:0]] = 1'b1;
      frame_in_use[hit]++;
      class_free[k]--;
      class_used[k]++;
      r.addr = (scsa_pkg::ADDR_W'(pfn) << scsa_pkg::FRAME_SIZE_LOG) +
               (scsa_pkg::ADDR_W'(slot) << (5 + k));
    end else begin
      pfn = fa[scsa_pkg::ADDR_W-1:scsa_pkg::FRAME_SIZE_LOG];
      rel = pfn - base_frame;
      if (rel >= NUM_FRAMES || !owner_of[rel][4]) begin
        r.status = scsa_pkg::RES_NOT_FOUND;
        return;
      end
      f = rel;
      k = owner_of[f][3:0];
      r.cls = 4'(k);
      slot = fa[scsa_pkg::FRAME_SIZE_LOG-1:0] >> (5 + k);
      word_idx = f*WORDS_PER_FRAME + ((slot >> 6) & (WORDS_PER_FRAME - 1));
      bit_mask = 64'd1 << slot[5:0];
      if ((slab_map[word_idx] & bit_mask) == 0) begin
        r.status = scsa_pkg::RES_ALREADY_FREE;
        return;
      end
      capacity = class_capacity(k);
      slab_map[word_idx] &= ~bit_mask;
      frame_in_use[f]--;
      class_free[k]++;
      class_used[k]--;
      if (frame_in_use[f] == 0 && f >= NUM_CLASSES && class_free[k] >= capacity * 3 / 2) begin
        owner_of[f] = '0;
        class_free[k] -= capacity;
        r.released = 1'b1;
      end
    end
  endtask

  task automatic send_request(input logic act, input logic [scsa_pkg::SIZE_W-1:0] sz,
                              input logic [scsa_pkg::ADDR_W-1:0] fa);
    alloc_result_t r;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    action = act;
    request_size = sz;
    free_address = fa;
    start = 1'b1;
    do @(posedge clk); while (busy);
    predict_request(act, sz, fa, r);
    pending_results.push_back(r);
    if (act == ACT_ALLOC && r.status == scsa_pkg::RES_OK)
      live_objects.push_back('{addr: r.addr, cls: r.cls});
    @(negedge clk);
    start = 1'b0;
    action = 1'($urandom_range(0, 1));
    request_size = scsa_pkg::SIZE_W'($urandom);
    free_address = scsa_pkg::ADDR_W'({$urandom, $urandom});
  endtask

  task automatic wait_until_drained();
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_pool_base(input logic [scsa_pkg::PFN_W-1:0] value);
    wait_until_drained();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    base_frame = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic free_everything();
    live_object_t obj;
    while (live_objects.size() != 0) begin
      obj = live_objects.pop_front();
      send_request(ACT_FREE, scsa_pkg::SIZE_W'($urandom), obj.addr);
    end
  endtask

  function automatic logic [scsa_pkg::SIZE_W-1:0] random_size();
    int unsigned k;
    k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5) : $urandom_range(6, 15);
    if (k == 0) return scsa_pkg::SIZE_W'($urandom_range(0, 32));
    return scsa_pkg::SIZE_W'($urandom_range((32 << k) / 2 + 1, 32 << k));
  endfunction

  task automatic test_directed_extremes();
    live_object_t obj;
    send_request(ACT_ALLOC, '0, '1);
    send_request(ACT_ALLOC, 21'd1, '0);
    send_request(ACT_ALLOC, 21'd32, '0);
    send_request(ACT_ALLOC, 21'd33, '0);
    send_request(ACT_ALLOC, scsa_pkg::MAX_SIZE, '0);
    send_request(ACT_ALLOC, scsa_pkg::MAX_SIZE + 21'd1, '0);
    send_request(ACT_ALLOC, '1, '0);
    send_request(ACT_FREE, '0, '1);
    send_request(ACT_FREE, '1, 48'h0000_0080_0000);
    obj = live_objects[1];
    send_request(ACT_FREE, '0, obj.addr + 48'd7);
    send_request(ACT_FREE, '0, obj.addr);
    live_objects.delete(1);
    send_request(ACT_FREE, '0, {scsa_pkg::ADDR_W{1'b0}});
    send_request(ACT_FREE, '0, 48'h0000_001f_ffff);
  endtask

  task automatic test_pool_exhaustion();
    live_object_t obj;
    repeat (36) send_request(ACT_ALLOC, scsa_pkg::MAX_SIZE, '0);
    send_request(ACT_ALLOC, 21'd40000, '0);
    wait_until_drained();
    while (live_objects.size() != 0) begin
      obj = live_objects.pop_back();
      send_request(ACT_FREE, '0, obj.addr);
      if ($urandom_range(0, 3) == 0) send_request(ACT_FREE, '0, obj.addr);
    end
  endtask

  task automatic test_random_traffic(input int items);
    int idx, pick;
    live_object_t obj;
    logic [scsa_pkg::ADDR_W-1:0] a;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        send_request(ACT_ALLOC, random_size(), scsa_pkg::ADDR_W'({$urandom, $urandom}));
      end else if (pick < 88 && live_objects.size() != 0) begin
        idx = $urandom_range(0, live_objects.size() - 1);
        obj = live_objects[idx];
        live_objects.delete(idx);
        freed_recently.push_back(obj.addr);
        if (freed_recently.size() > 8) void'(freed_recently.pop_front());
        a = obj.addr;
        if ($urandom_range(0, 4) == 0)
          a = a + ($urandom & ((scsa_pkg::ADDR_W'(32) << obj.cls) - 1));
        send_request(ACT_FREE, scsa_pkg::SIZE_W'($urandom), a);
      end else if (pick < 93 && freed_recently.size() != 0) begin
        send_request(ACT_FREE, scsa_pkg::SIZE_W'($urandom),
                     freed_recently[$urandom_range(0, freed_recently.size() - 1)]);
      end else if (pick < 96) begin
        send_request(ACT_ALLOC, scsa_pkg::SIZE_W'($urandom),
                     scsa_pkg::ADDR_W'({$urandom, $urandom}));
      end else begin
        a = scsa_pkg::ADDR_W'({$urandom, $urandom});
        if ($urandom_range(0, 1))
          a[scsa_pkg::ADDR_W-1:scsa_pkg::FRAME_SIZE_LOG] =
            scsa_pkg::PFN_W'(base_frame + $urandom_range(0, 40));
        send_request(ACT_FREE, scsa_pkg::SIZE_W'($urandom), a);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    alloc_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status expected %0d got %0d", want.status, status);
          errors++;
        end
        if (object_address !== want.addr) begin
          $error("object_address expected %h got %h", want.addr, object_address);
          errors++;
        end
        if (size_class !== want.cls) begin
          $error("size_class expected %0d got %0d", want.cls, size_class);
          errors++;
        end
        if (frame_released !== want.released) begin
          $error("frame_released expected %0d got %0d", want.released, frame_released);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_extremes();
    test_pool_exhaustion();
    free_everything();
    write_pool_base({scsa_pkg::PFN_W{1'b1}});
    test_random_traffic(560);
    free_everything();
    write_pool_base(scsa_pkg::PFN_W'($urandom));
    test_random_traffic(560);
    free_everything();
    write_pool_base('0);
    idling_on = 1'b0;
    test_random_traffic(520);
    wait_until_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
